// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock with an active-low reset.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same assertion on the usual clock and reset names.
`define CHK_ASSERT_STD(label, prop, msg) \
    `CHK_ASSERT(label, i_clk, i_rst_n, prop, msg)

`endif

// ----- rtl/omik_pkg.sv -----
`timescale 1ns / 1ps
package omik_pkg;
    localparam int MAX_WHEELS = 4;
    localparam int WHEELS_DEF = 4;
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;
    localparam int GEOM_W     = 48;
    localparam int SPEED_W    = 16;
    localparam int LIMIT_W    = 15;
    localparam int ACT_W      = 3;

    localparam logic [2:0] REG_GEOM_0    = 3'd0;
    localparam logic [2:0] REG_GEOM_1    = 3'd1;
    localparam logic [2:0] REG_GEOM_2    = 3'd2;
    localparam logic [2:0] REG_GEOM_3    = 3'd3;
    localparam logic [2:0] REG_MAX_SPEED = 3'd4;
    localparam logic [2:0] REG_ACTIVE    = 3'd5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 15'd24576;
    localparam logic [ACT_W-1:0]   ACTIVE_RESET = 3'd4;
    localparam logic [ACT_W-1:0]   ACTIVE_MIN   = 3'd3;

    localparam logic [14:0] SIN_A   = 15'd25736;
    localparam logic [13:0] SIN_B   = 14'd10512;
    localparam logic [10:0] SIN_C   = 11'd1160;
    localparam logic [15:0] QUARTER = 16'd16384;

    localparam int DEAD_ZONE  = 2;
    localparam int DIV_STAGES = 15;
    localparam int LATENCY    = 13 + DIV_STAGES;
endpackage

// ----- rtl/omniwheel_inverse_kinematics.sv -----
`timescale 1ns / 1ps
// Omni-wheel inverse kinematics.
// A command transaction is taken at each rising edge with start high; busy is
// always low, so a new command may be issued in every cycle.
// The command is a field-frame velocity (mm/s), a turn rate (Q4.11 rad/s)
// and the heading as a 16-bit binary angle. The block returns one speed per
// wheel in Q4.11 revolutions per second and a flag set when the speeds were
// scaled down to the configured limit.
// Each result appears on the o_ ports for exactly one cycle with o_valid high.
// Throughput is one command per cycle; the latency is set by the four-stage
// sine pipeline, the multiply chain, the largest-magnitude search and the
// 15-stage restoring divider that performs the proportional limit scaling,
// one quotient bit per stage.
// Wheel geometry, the speed limit and the active wheel count must be written
// by the user via APB only while no command is in flight (not enforced).
// Reset clears the pipeline valid bits and loads the register defaults;
// commands in flight are dropped. The receiver cannot stall the block.
module omniwheel_inverse_kinematics #(
    parameter int WHEELS = omik_pkg::WHEELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [omik_pkg::SPEED_W-1:0] i_vel_x,
    input  logic signed [omik_pkg::SPEED_W-1:0] i_vel_y,
    input  logic signed [omik_pkg::SPEED_W-1:0] i_vel_turn,
    input  logic signed [omik_pkg::SPEED_W-1:0] i_heading,
    output logic                                o_valid,
    output logic signed [omik_pkg::SPEED_W-1:0] o_wheel_speed_0,
    output logic signed [omik_pkg::SPEED_W-1:0] o_wheel_speed_1,
    output logic signed [omik_pkg::SPEED_W-1:0] o_wheel_speed_2,
    output logic signed [omik_pkg::SPEED_W-1:0] o_wheel_speed_3,
    output logic                                o_was_limited,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [omik_pkg::ADDR_W-1:0]         paddr,
    input  logic [omik_pkg::DATA_W-1:0]         pwdata,
    output logic [omik_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import omik_pkg::*;

    localparam int NANG = 2 + 2 * WHEELS;
    localparam int UW   = 34;
    localparam int LW   = 52;
    localparam int MW   = 34;
    localparam int PW   = 51;
    localparam int MAGW = 29;
    localparam int NUMW = 46;
    localparam int DENW = MAGW + 1;

    typedef struct packed {
        logic                sg;
        logic [SPEED_W-1:0]  lo;
        logic [NUMW-1:0]     rem;
        logic [LIMIT_W-1:0]  q;
    } t_lane;

    typedef struct packed {
        logic            dead;
        logic            lmt;
        logic [DENW-1:0] den;
    } t_ctl;

    logic [GEOM_W-1:0]  r_geom [MAX_WHEELS];
    logic [LIMIT_W-1:0] r_limit;
    logic [ACT_W-1:0]   r_active;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WHEELS; i++) begin
                r_geom[i] <= '0;
            end
            r_limit  <= LIMIT_RESET;
            r_active <= ACTIVE_RESET;
        end else if (cfg_wr) begin
            if (cfg_idx < REG_MAX_SPEED) begin
                r_geom[cfg_idx[1:0]] <= pwdata[GEOM_W-1:0];
            end else if (cfg_idx == REG_MAX_SPEED) begin
                r_limit <= pwdata[LIMIT_W-1:0];
            end else if (cfg_idx == REG_ACTIVE) begin
                r_active <= pwdata[ACT_W-1:0];
            end
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_GEOM_0:      prdata = DATA_W'(r_geom[0]);
            REG_GEOM_1:      prdata = DATA_W'(r_geom[1]);
            REG_GEOM_2:      prdata = DATA_W'(r_geom[2]);
            REG_GEOM_3:      prdata = DATA_W'(r_geom[3]);
            REG_MAX_SPEED:   prdata = DATA_W'(r_limit);
            REG_ACTIVE:      prdata = DATA_W'(r_active);
            default:         prdata = '0;
        endcase
    end

    logic [LATENCY-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], start & ~busy};
        end
    end

    logic signed [SPEED_W-1:0] r_vx [5];
    logic signed [SPEED_W-1:0] r_vy [5];
    logic signed [SPEED_W-1:0] r_w  [6];
    logic [SPEED_W-1:0]        r_hd0;

    always_ff @(posedge i_clk) begin
        r_vx[0] <= i_vel_x;
        r_vy[0] <= i_vel_y;
        r_w[0]  <= i_vel_turn;
        r_hd0   <= i_heading;
        for (int j = 1; j < 5; j++) begin
            r_vx[j] <= r_vx[j-1];
            r_vy[j] <= r_vy[j-1];
        end
        for (int j = 1; j < 6; j++) begin
            r_w[j] <= r_w[j-1];
        end
    end

    logic [15:0]        ang [NANG];
    logic [14:0]        z_c [NANG];
    logic [1:0]         r_q1 [NANG], r_q2 [NANG], r_q3 [NANG];
    logic [14:0]        r_z1 [NANG], r_z2 [NANG], r_z3 [NANG];
    logic [14:0]        r_zz1 [NANG], r_zz2 [NANG];
    logic [13:0]        r_tb2 [NANG];
    logic [14:0]        r_ta3 [NANG];
    logic signed [16:0] r_s4 [NANG];

    always_comb begin
        ang[0] = r_hd0;
        ang[1] = r_hd0 + QUARTER;
        for (int i = 0; i < WHEELS; i++) begin
            ang[2+2*i] = r_geom[i][15:0];
            ang[3+2*i] = r_geom[i][15:0] + QUARTER;
        end
        for (int k = 0; k < NANG; k++) begin
            z_c[k] = ang[k][14] ? 15'(15'd16384 - {1'b0, ang[k][13:0]})
                                : {1'b0, ang[k][13:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NANG; k++) begin
            r_q1[k]  <= ang[k][15:14];
            r_z1[k]  <= z_c[k];
            r_zz1[k] <= 15'((30'(z_c[k]) * 30'(z_c[k])) >> 14);
            r_q2[k]  <= r_q1[k];
            r_z2[k]  <= r_z1[k];
            r_zz2[k] <= r_zz1[k];
            r_tb2[k] <= SIN_B - 14'((26'(SIN_C) * 26'(r_zz1[k])) >> 14);
            r_q3[k]  <= r_q2[k];
            r_z3[k]  <= r_z2[k];
            r_ta3[k] <= SIN_A - 15'((29'(r_zz2[k]) * 29'(r_tb2[k])) >> 14);
            r_s4[k]  <= r_q3[k][1]
                ? -$signed({2'b00, 15'((30'(r_z3[k]) * 30'(r_ta3[k])) >> 14)})
                :  $signed({2'b00, 15'((30'(r_z3[k]) * 30'(r_ta3[k])) >> 14)});
        end
    end

    logic signed [UW-1:0]   r_u5, r_v5;
    logic signed [16:0]     r_wc5 [WHEELS], r_ws5 [WHEELS];
    logic signed [LW-1:0]   r_lin6 [WHEELS];
    logic signed [MW-1:0]   r_wd6 [WHEELS];
    logic [LW-1:0]          lin_mag [WHEELS];
    logic [LW-1:0]          lin_rnd [WHEELS];
    logic signed [MW-1:0]   r_mms7 [WHEELS];
    logic signed [PW-1:0]   r_prod8 [WHEELS];
    logic [PW-1:0]          prod_mag [WHEELS];
    logic [PW-1:0]          prod_rnd [WHEELS];
    logic                   r_sg9 [WHEELS], r_sg10 [WHEELS];
    logic [MAGW-1:0]        r_mg9 [WHEELS], r_mg10 [WHEELS];
    logic [ACT_W-1:0]       n_act;
    logic [MAGW-1:0]        big_c;
    logic [MAGW-1:0]        r_big10;

    always_comb begin
        if (r_active < ACTIVE_MIN) begin
            n_act = ACTIVE_MIN;
        end else if (int'(r_active) > WHEELS) begin
            n_act = ACT_W'(WHEELS);
        end else begin
            n_act = r_active;
        end
        for (int i = 0; i < WHEELS; i++) begin
            lin_mag[i]  = r_lin6[i][LW-1] ? LW'(-r_lin6[i]) : LW'(r_lin6[i]);
            lin_rnd[i]  = (lin_mag[i] + (LW'(1) << 16)) >> 17;
            prod_mag[i] = r_prod8[i][PW-1] ? PW'(-r_prod8[i]) : PW'(r_prod8[i]);
            prod_rnd[i] = (prod_mag[i] + (PW'(1) << 21)) >> 22;
        end
        big_c = '0;
        for (int i = 0; i < WHEELS; i++) begin
            if (r_mg9[i] > big_c) begin
                big_c = r_mg9[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_u5 <= UW'(r_vy[4]) * UW'(r_s4[1]) - UW'(r_vx[4]) * UW'(r_s4[0]);
        r_v5 <= UW'(r_vx[4]) * UW'(r_s4[1]) + UW'(r_vy[4]) * UW'(r_s4[0]);
        for (int i = 0; i < WHEELS; i++) begin
            r_wc5[i]  <= r_s4[3+2*i];
            r_ws5[i]  <= r_s4[2+2*i];
            r_lin6[i] <= LW'(r_wc5[i]) * LW'(r_u5) - LW'(r_ws5[i]) * LW'(r_v5);
            r_wd6[i]  <= MW'(r_w[5]) * MW'($signed({1'b0, r_geom[i][31:16]}));
            r_mms7[i] <= (r_lin6[i][LW-1] ? -$signed(MW'(lin_rnd[i]))
                                           :  $signed(MW'(lin_rnd[i]))) + r_wd6[i];
            r_prod8[i] <= PW'(r_mms7[i]) * PW'($signed({1'b0, r_geom[i][47:32]}));
            r_sg9[i]  <= r_prod8[i][PW-1];
            r_mg9[i]  <= (i < int'(n_act)) ? MAGW'(prod_rnd[i]) : '0;
            r_sg10[i] <= r_sg9[i];
            r_mg10[i] <= r_mg9[i];
        end
        r_big10 <= big_c;
    end

    t_lane r_l11 [WHEELS];
    t_ctl  r_c11;
    t_lane r_dl [DIV_STAGES][WHEELS];
    t_ctl  r_dc [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        r_c11.dead <= (r_big10 <= MAGW'(DEAD_ZONE));
        r_c11.lmt  <= (r_big10 > MAGW'(r_limit));
        r_c11.den  <= {r_big10, 1'b0};
        for (int i = 0; i < WHEELS; i++) begin
            r_l11[i].sg  <= r_sg10[i];
            r_l11[i].lo  <= r_sg10[i] ? SPEED_W'(-r_mg10[i]) : r_mg10[i][SPEED_W-1:0];
            r_l11[i].rem <= ((NUMW'(r_mg10[i]) * NUMW'(r_limit)) << 1) + NUMW'(r_big10);
            r_l11[i].q   <= '0;
        end
    end

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        localparam int BIT = DIV_STAGES - 1 - j;
        t_lane src_l [WHEELS];
        t_lane n_dl [WHEELS];
        t_ctl  src_c;
        logic [NUMW-1:0] dsh;

        if (j == 0) begin : g_first
            assign src_l = r_l11;
            assign src_c = r_c11;
        end else begin : g_next
            assign src_l = r_dl[j-1];
            assign src_c = r_dc[j-1];
        end

        assign dsh = NUMW'(src_c.den) << BIT;

        always_comb begin
            for (int i = 0; i < WHEELS; i++) begin
                n_dl[i] = src_l[i];
                if (src_l[i].rem >= dsh) begin
                    n_dl[i].rem    = src_l[i].rem - dsh;
                    n_dl[i].q[BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_dc[j] <= src_c;
            r_dl[j] <= n_dl;
        end
    end

    logic signed [SPEED_W-1:0] r_out [MAX_WHEELS];
    logic                      r_lim_out;
    t_ctl                      last_c;

    assign last_c = r_dc[DIV_STAGES-1];

    for (genvar i = 0; i < MAX_WHEELS; i++) begin : g_out
        if (i < WHEELS) begin : g_used
            t_lane last_l;
            assign last_l = r_dl[DIV_STAGES-1][i];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_out[i] <= '0;
                end else if (!r_vld[LATENCY-2] || last_c.dead) begin
                    r_out[i] <= '0;
                end else if (last_c.lmt) begin
                    r_out[i] <= last_l.sg ? -$signed({1'b0, last_l.q})
                                          :  $signed({1'b0, last_l.q});
                end else begin
                    r_out[i] <= $signed(last_l.lo);
                end
            end
        end else begin : g_unused
            always_ff @(posedge i_clk) begin
                r_out[i] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_out <= 1'b0;
        end else begin
            r_lim_out <= r_vld[LATENCY-2] & ~last_c.dead & last_c.lmt;
        end
    end

    assign o_valid         = r_vld[LATENCY-1];
    assign o_wheel_speed_0 = r_out[0];
    assign o_wheel_speed_1 = r_out[1];
    assign o_wheel_speed_2 = r_out[2];
    assign o_wheel_speed_3 = r_out[3];
    assign o_was_limited   = r_lim_out;
endmodule

// ----- rtl/omik_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module omik_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_valid,
    input logic signed [omik_pkg::SPEED_W-1:0] o_wheel_speed_0,
    input logic signed [omik_pkg::SPEED_W-1:0] o_wheel_speed_1,
    input logic signed [omik_pkg::SPEED_W-1:0] o_wheel_speed_2,
    input logic signed [omik_pkg::SPEED_W-1:0] o_wheel_speed_3,
    input logic                                o_was_limited,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic                                pready,
    input logic [omik_pkg::ADDR_W-1:0]         paddr,
    input logic [omik_pkg::DATA_W-1:0]         pwdata,
    input logic [omik_pkg::DATA_W-1:0]         prdata
);
    import omik_pkg::*;

    `CHK_ASSERT_STD(a_result_has_cmd, o_valid |-> $past(start && !busy, LATENCY),
        "result without a command transaction")
    `CHK_ASSERT_STD(a_cmd_gives_result, (start && !busy) |-> ##LATENCY o_valid,
        "command transaction without a result")
    `CHK_ASSERT_STD(a_idle_outputs_zero,
        !o_valid |-> (o_wheel_speed_0 == 0 && o_wheel_speed_1 == 0 &&
        o_wheel_speed_2 == 0 && o_wheel_speed_3 == 0 && !o_was_limited),
        "result ports not cleared between transactions")
    `CHK_ASSERT_STD(a_limit_readback,
        (psel && penable && pwrite && pready && paddr[5:3] == REG_MAX_SPEED) ##1
        (paddr[5:3] == REG_MAX_SPEED) |-> prdata[LIMIT_W-1:0] == $past(pwdata[LIMIT_W-1:0]),
        "speed limit readback mismatch")
endmodule

bind omniwheel_inverse_kinematics omik_checker u_omik_checker (.*);
